// File: rtl/mcht_pkg.sv
// Shared op codes and field widths for the monotone convex hull trick block.
package mcht_pkg;

    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 64;
    localparam int X_W     = 32;
    localparam int LINE_W  = SLOPE_W + ICPT_W;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

endpackage

// File: rtl/monotone_convex_hull_trick.sv
// Monotone convex hull trick: deque of lines kept as an upper envelope, max queries.
//
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+---------------------------------
//  command   | start, i_op, i_slope, i_intercept, i_x       | beat taken when start && !busy
//  result    | o_done, o_value, o_full_res, o_line_count    | one-cycle strobe, no backpressure
//
//  Clear, no-op, a full insert and a query on an empty hull go straight to the result; a
//  query pops front lines while the next line is not lower at x; an insert into an empty
//  hull is pushed at once, a new line with the back line's slope and a lower intercept is
//  dropped, otherwise back lines are popped while redundant. The pop loops run on one
//  line store (one write port, one registered read port) and one shared 32x33
//  multiplier (the redundancy cross products take four partial products).
//  Reset (synchronous, active low) empties the hull; the line store is not cleared,
//  since only held entries are ever read. busy drops in the cycle the result strobes;
//  the receiver cannot stall the result.
module monotone_convex_hull_trick #(
    parameter int HULL_DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              i_op,
    input  logic signed [mcht_pkg::SLOPE_W-1:0]     i_slope,
    input  logic signed [mcht_pkg::ICPT_W-1:0]      i_intercept,
    input  logic signed [mcht_pkg::X_W-1:0]         i_x,
    output logic                                    o_done,
    output logic signed [mcht_pkg::ICPT_W-1:0]      o_value,
    output logic                                    o_full_res,
    output logic [$clog2(HULL_DEPTH+1)-1:0]         o_line_count
);

    localparam int AW = $clog2(HULL_DEPTH);
    localparam int CW = $clog2(HULL_DEPTH + 1);
    localparam int SW = mcht_pkg::SLOPE_W;
    localparam int IW = mcht_pkg::ICPT_W;
    localparam int LW = mcht_pkg::LINE_W;
    localparam logic [CW:0]   DEPTH_W = (CW+1)'(HULL_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(HULL_DEPTH);

    // one-hot sequencer
    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_EQRD  = 22'h000002,  // read back line
        S_EQCHK = 22'h000004,  // equal-slope check
        S_LOOP  = 22'h000008,  // back pop loop head
        S_RDA   = 22'h000010,
        S_RDB   = 22'h000020,
        S_PREP  = 22'h000040,  // numerators and denominators
        S_ABS   = 22'h000080,  // magnitudes
        S_M0    = 22'h000100,
        S_M1    = 22'h000200,
        S_M2    = 22'h000400,
        S_M3    = 22'h000800,
        S_M4    = 22'h001000,
        S_CMP   = 22'h002000,  // redundancy decision
        S_WR    = 22'h004000,  // push new line
        S_QRA   = 22'h008000,
        S_QRB   = 22'h010000,
        S_QE0   = 22'h020000,
        S_QE1   = 22'h040000,
        S_QE2   = 22'h080000,
        S_QCMP  = 22'h100000,
        S_DONE  = 22'h200000
    } t_state;

    t_state r_state;

    logic [CW-1:0]  r_cnt;
    logic [AW-1:0]  r_front;
    logic           r_done;
    logic           r_full;
    logic [IW-1:0]  r_val;

    // latched command
    logic [SW-1:0]  r_slope;
    logic [IW-1:0]  r_icpt;
    logic [SW-1:0]  r_xmag;
    logic           r_xneg;

    // line store
    logic [LW-1:0]  r_mem [HULL_DEPTH];
    logic [LW-1:0]  r_rdata;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic [LW-1:0]  r_la;
    logic [LW-1:0]  r_lb;

    // redundancy datapath
    logic [IW:0]    r_nl, r_nr;
    logic [SW:0]    r_d1, r_d2;
    logic [IW-1:0]  r_magl, r_magr;
    logic           r_negl, r_negr;
    logic [SW:0]    r_dml, r_dmr;
    logic [96:0]    r_accl, r_accr;

    // shared multiplier
    logic [31:0]    mul_a;
    logic [32:0]    mul_b;
    logic [64:0]    r_prod;
    logic           r_pneg;
    logic           mul_sneg;

    logic [IW-1:0]  r_v0, r_v1;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] f, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, f} + {1'b0, k};
        if (s >= DEPTH_W) begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [SW:0] f_abs(input logic [SW-1:0] s);
        logic [SW:0] e;
        e = {s[SW-1], s};
        return e[SW] ? (~e + 1'b1) : e;
    endfunction

    function automatic logic sgt(input logic [IW-1:0] p, input logic [IW-1:0] q);
        return $signed(p) > $signed(q);
    endfunction

    // read address by step
    always_comb begin
        unique case (r_state)
            S_EQRD, S_RDB: rd_addr = f_slot(r_front, r_cnt - CW'(1));
            S_RDA:         rd_addr = f_slot(r_front, r_cnt - CW'(2));
            S_QRB:         rd_addr = f_slot(r_front, CW'(1));
            default:       rd_addr = f_slot(r_front, '0);
        endcase
    end

    assign wr_addr = f_slot(r_front, r_cnt);

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_mem[wr_addr] <= {r_slope, r_icpt};
        end
        r_rdata <= r_mem[rd_addr];
    end

    // multiplier operand select
    always_comb begin
        mul_a    = r_xmag;
        mul_b    = f_abs(r_la[LW-1:IW]);
        mul_sneg = r_xneg ^ r_la[LW-1];
        unique case (r_state)
            S_M0: begin
                mul_a = r_magl[31:0];
                mul_b = r_dml;
            end
            S_M1: begin
                mul_a = r_magl[63:32];
                mul_b = r_dml;
            end
            S_M2: begin
                mul_a = r_magr[31:0];
                mul_b = r_dmr;
            end
            S_M3: begin
                mul_a = r_magr[63:32];
                mul_b = r_dmr;
            end
            S_QE1: begin
                mul_b    = f_abs(r_lb[LW-1:IW]);
                mul_sneg = r_xneg ^ r_lb[LW-1];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 65'(mul_a) * 65'(mul_b);
        r_pneg <= mul_sneg;
    end

    // sequencer and datapath
    logic        negl_nz, negr_nz, le_mag, ge_mag, redund;
    logic [SW:0] d1_c, d2_c;
    logic [IW-1:0] ev;

    always_comb begin
        negl_nz = r_negl && (r_accl != '0);
        negr_nz = r_negr && (r_accr != '0);
        le_mag  = r_accl <= r_accr;
        ge_mag  = r_accl >= r_accr;
        if (negl_nz != negr_nz) begin
            redund = negl_nz;
        end else if (negl_nz) begin
            redund = ge_mag;
        end else begin
            redund = le_mag;
        end
        d1_c = {r_slope[SW-1], r_slope} - {r_rdata[LW-1], r_rdata[LW-1:IW]};
        d2_c = {r_la[LW-1], r_la[LW-1:IW]} - {r_rdata[LW-1], r_rdata[LW-1:IW]};
        ev   = r_pneg ? (r_lb[IW-1:0] - r_prod[IW-1:0]) : (r_lb[IW-1:0] + r_prod[IW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_front <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_slope <= i_slope;
                        r_icpt  <= i_intercept;
                        r_xmag  <= i_x[SW-1] ? (~i_x + 1'b1) : i_x;
                        r_xneg  <= i_x[SW-1];
                        r_full  <= 1'b0;
                        r_val   <= '0;
                        unique case (mcht_pkg::t_op'(i_op))
                            mcht_pkg::OP_INSERT: begin
                                if (r_cnt == DEPTH_C) begin
                                    r_full  <= 1'b1;
                                    r_state <= S_DONE;
                                end else if (r_cnt == '0) begin
                                    r_state <= S_WR;
                                end else begin
                                    r_state <= S_EQRD;
                                end
                            end
                            mcht_pkg::OP_QUERY: begin
                                r_state <= (r_cnt == '0) ? S_DONE : S_QRA;
                            end
                            mcht_pkg::OP_CLEAR: begin
                                r_front <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_EQRD: r_state <= S_EQCHK;
                S_EQCHK: begin
                    if (r_rdata[LW-1:IW] == r_slope) begin
                        if (sgt(r_rdata[IW-1:0], r_icpt)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_cnt   <= r_cnt - CW'(1);
                            r_state <= S_LOOP;
                        end
                    end else begin
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: r_state <= (r_cnt > CW'(1)) ? S_RDA : S_WR;
                S_RDA:  r_state <= S_RDB;
                S_RDB: begin
                    r_la    <= r_rdata;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    // line b is in r_rdata, line a in r_la, new line c in the command
                    r_d1 <= d1_c;
                    r_d2 <= d2_c;
                    r_nl <= d1_c[SW]
                        ? ({r_icpt[IW-1], r_icpt} - {r_rdata[IW-1], r_rdata[IW-1:0]})
                        : ({r_rdata[IW-1], r_rdata[IW-1:0]} - {r_icpt[IW-1], r_icpt});
                    r_nr <= d2_c[SW]
                        ? ({r_la[IW-1], r_la[IW-1:0]} - {r_rdata[IW-1], r_rdata[IW-1:0]})
                        : ({r_rdata[IW-1], r_rdata[IW-1:0]} - {r_la[IW-1], r_la[IW-1:0]});
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_negl  <= r_nl[IW];
                    r_negr  <= r_nr[IW];
                    r_magl  <= r_nl[IW] ? IW'(~r_nl + 1'b1) : r_nl[IW-1:0];
                    r_magr  <= r_nr[IW] ? IW'(~r_nr + 1'b1) : r_nr[IW-1:0];
                    r_dml   <= r_d2[SW] ? (~r_d2 + 1'b1) : r_d2;
                    r_dmr   <= r_d1[SW] ? (~r_d1 + 1'b1) : r_d1;
                    r_state <= S_M0;
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_accl  <= 97'(r_prod);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_accl  <= r_accl + {r_prod, 32'b0};
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_accr  <= 97'(r_prod);
                    r_state <= S_M4;
                end
                S_M4: begin
                    r_accr  <= r_accr + {r_prod, 32'b0};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (redund) begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_LOOP;
                    end else begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_DONE;
                end
                S_QRA: r_state <= S_QRB;
                S_QRB: begin
                    r_la    <= r_rdata;
                    r_state <= S_QE0;
                end
                S_QE0: begin
                    // front line product in flight; hold its intercept for the add
                    r_lb    <= r_rdata;
                    r_v1    <= r_la[IW-1:0];
                    r_state <= S_QE1;
                end
                S_QE1: begin
                    r_v0    <= r_pneg ? (r_v1 - r_prod[IW-1:0]) : (r_v1 + r_prod[IW-1:0]);
                    r_state <= S_QE2;
                end
                S_QE2: begin
                    r_v1    <= ev;
                    r_state <= S_QCMP;
                end
                S_QCMP: begin
                    if (r_cnt > CW'(1) && !sgt(r_v0, r_v1)) begin
                        r_front <= f_slot(r_front, CW'(1));
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_QRA;
                    end else begin
                        r_val   <= r_v0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_value      = r_val;
    assign o_full_res   = r_full;
    assign o_line_count = r_cnt;

endmodule

// File: rtl/mcht_chk.sv
// Port-level assertions for the hull block, bound to the top level.
module mcht_chk #(
    parameter int HULL_DEPTH = 1024
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_done,
    input logic                                o_full_res,
    input logic [$clog2(HULL_DEPTH+1)-1:0]     o_line_count
);

    localparam logic [$clog2(HULL_DEPTH+1)-1:0] DEPTH_C = ($clog2(HULL_DEPTH+1))'(HULL_DEPTH);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy) && !busy)
        else $error("result beat without a command in flight");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_line_count <= DEPTH_C)
        else $error("line count above store depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_full_res |-> o_line_count == DEPTH_C)
        else $error("full flag with room left");

endmodule

bind monotone_convex_hull_trick mcht_chk #(.HULL_DEPTH(HULL_DEPTH)) u_mcht_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_full_res   (o_full_res),
    .o_line_count (o_line_count)
);
